// ===== rtl/pcpw_pkg.sv =====
// Package for the plane-constrained periodic wrap block.
// Holds payload structs, register indexes and sequencer state type.
`timescale 1ns / 1ps
package pcpw_pkg;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] REG_COEF_A   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_B   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_C   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_D   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BOX_EDGE = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RECIP_A  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_RECIP_B  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RECIP_C  = 3'd7;

   localparam logic [30:0] BOX_EDGE_RESET = 31'd65536;

   typedef struct packed {
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
      logic               is_oxygen;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [5:0]         rounds_used;
      logic               limit_hit;
   } rsp_type;

   // coordinate selector
   typedef enum logic [1:0] {
      AX_X = 2'd0,
      AX_Y = 2'd1,
      AX_Z = 2'd2
   } axis_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REM,
      ST_MUL1,
      ST_MUL2,
      ST_SUM,
      ST_MUL3,
      ST_STORE,
      ST_NEXT,
      ST_DONE
   } state_type;

   // divider control/status
   typedef struct packed {
      logic        start;
      logic [32:0] dividend;
   } div_ctl_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic signed [32:0] rem;
   } div_sts_type;

   // Q16.16 product truncated toward zero (operands 32 bit signed)
   function automatic logic signed [49:0] mulq_trunc(input logic signed [63:0] p);
      logic signed [63:0] mag;
      logic signed [63:0] sh;
      begin
         mag = p[63] ? -p : p;
         sh  = mag >>> 16;
         mulq_trunc = p[63] ? -sh[49:0] : sh[49:0];
      end
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
      begin
         if (v > 52'sd2147483647)
            sat32 = 32'sh7FFFFFFF;
         else if (v < -52'sd2147483648)
            sat32 = 32'sh80000000;
         else
            sat32 = v[31:0];
      end
   endfunction

endpackage

// ===== rtl/pcpw_rem.sv =====
// Bit-serial truncating remainder by the box edge, one quotient bit a cycle.
// Depends on pcpw_pkg.
`timescale 1ns / 1ps
module pcpw_rem (
   input  logic                  clock,
   input  logic                  reset,
   input  pcpw_pkg::div_ctl_type ctl,
   input  logic [30:0]           box_edge,
   output pcpw_pkg::div_sts_type sts
);

   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] mag_ff, mag_in;
   logic [31:0] rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] trial;
   logic [32:0] sub;

   always_comb begin
      trial = {rem_ff[30:0], mag_ff[32]};
      sub   = {1'b0, trial} - {2'b00, box_edge};
   end

   always_comb begin
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         neg_in  = ctl.dividend[32];
         mag_in  = ctl.dividend[32] ? -ctl.dividend : ctl.dividend;
         rem_in  = '0;
         cnt_in  = 6'd33;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = {mag_ff[31:0], 1'b0};
         rem_in = sub[32] ? trial : sub[31:0];
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      sts.busy = busy_ff;
      sts.done = done_ff;
      if (box_edge == 31'd0)
         sts.rem = '0;
      else
         sts.rem = neg_ff ? -$signed({1'b0, rem_ff}) : $signed({1'b0, rem_ff});
   end

`ifndef SYNTHESIS
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("remainder done held");
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("remainder done without busy");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 6'd0)
      else $error("remainder counter underflow");
`endif

endmodule

// ===== rtl/plane_constrained_periodic_wrap.sv =====
// Channels:
//   name  direction  handshake             payload
//   req   in         start & !busy         pcpw_pkg::req_type
//   rsp   out        rsp_valid (1 cycle)   pcpw_pkg::rsp_type
//   csr   in         csr_we                csr_index, csr_wdata
// A pass-through site goes straight to the response. An oxygen site is
// checked round by round, one coordinate at a time; each wrapped one runs
// the 33-step serial remainder and three shared multiplies.
// Reset is synchronous; control and CSR registers take their reset values, coordinate and datapath registers do not.
// The receiver cannot stall; rsp_valid is high for one cycle.
// Depends on pcpw_pkg and pcpw_rem.
`timescale 1ns / 1ps
module plane_constrained_periodic_wrap #(
   parameter int unsigned ROUND_LIMIT = 50
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         start,
   output logic                                         busy,
   input  pcpw_pkg::req_type                            req_data,
   output logic                                         rsp_valid,
   output pcpw_pkg::rsp_type                            rsp_data,
   input  logic                                         csr_we,
   input  logic [pcpw_pkg::CSR_IDX_W-1:0]               csr_index,
   input  logic [pcpw_pkg::CSR_DATA_W-1:0]              csr_wdata
);

   localparam int unsigned RND_W = $clog2(ROUND_LIMIT + 2);

   logic signed [31:0] coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic signed [31:0] recip_a_ff, recip_b_ff, recip_c_ff;
   logic [30:0]        box_ff;

   pcpw_pkg::state_type state_ff, state_in;
   pcpw_pkg::axis_type  axis_ff, axis_in;
   logic signed [31:0]  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [RND_W-1:0]    rnd_ff, rnd_in;
   logic                crossed_ff, crossed_in;
   logic                limit_ff, limit_in;
   logic signed [51:0]  acc_ff, acc_in;
   logic signed [31:0]  res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;

   pcpw_pkg::div_ctl_type div_ctl;
   pcpw_pkg::div_sts_type div_sts;

   logic signed [31:0] cur;
   logic               outside;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] prod;
   logic signed [49:0] prodq;
   logic signed [31:0] neg_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff  <= '0;
         coef_b_ff  <= '0;
         coef_c_ff  <= '0;
         coef_d_ff  <= '0;
         box_ff     <= pcpw_pkg::BOX_EDGE_RESET;
         recip_a_ff <= '0;
         recip_b_ff <= '0;
         recip_c_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            pcpw_pkg::REG_COEF_A:   coef_a_ff  <= csr_wdata;
            pcpw_pkg::REG_COEF_B:   coef_b_ff  <= csr_wdata;
            pcpw_pkg::REG_COEF_C:   coef_c_ff  <= csr_wdata;
            pcpw_pkg::REG_COEF_D:   coef_d_ff  <= csr_wdata;
            pcpw_pkg::REG_BOX_EDGE: box_ff     <= csr_wdata[30:0];
            pcpw_pkg::REG_RECIP_A:  recip_a_ff <= csr_wdata;
            pcpw_pkg::REG_RECIP_B:  recip_b_ff <= csr_wdata;
            pcpw_pkg::REG_RECIP_C:  recip_c_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pcpw_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .box_edge (box_ff),
      .sts      (div_sts)
   );

   always_comb begin
      case (axis_ff)
         pcpw_pkg::AX_X: cur = x_ff;
         pcpw_pkg::AX_Y: cur = y_ff;
         default:        cur = z_ff;
      endcase
      outside = cur[31] || ($signed({1'b0, cur}) > $signed({2'b00, box_ff}));
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         pcpw_pkg::ST_MUL1: begin
            case (axis_ff)
               pcpw_pkg::AX_X: begin mul_a = coef_a_ff; mul_b = x_ff; end
               pcpw_pkg::AX_Y: begin mul_a = coef_b_ff; mul_b = y_ff; end
               default:        begin mul_a = coef_a_ff; mul_b = x_ff; end
            endcase
         end
         pcpw_pkg::ST_MUL2: begin
            case (axis_ff)
               pcpw_pkg::AX_X: begin mul_a = coef_b_ff; mul_b = y_ff; end
               default:        begin mul_a = coef_c_ff; mul_b = z_ff; end
            endcase
         end
         pcpw_pkg::ST_MUL3: begin
            mul_a = res_ff;
            case (axis_ff)
               pcpw_pkg::AX_X: mul_b = recip_c_ff;
               pcpw_pkg::AX_Y: mul_b = recip_a_ff;
               default:        mul_b = recip_b_ff;
            endcase
         end
         default: ;
      endcase
      prod    = mul_a * mul_b;
      prodq   = pcpw_pkg::mulq_trunc(prod);
      neg_sat = pcpw_pkg::sat32(-(acc_ff + 52'(coef_d_ff)));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pcpw_pkg::ST_IDLE:
            if (start)
               state_in = req_data.is_oxygen ? pcpw_pkg::ST_CHECK : pcpw_pkg::ST_DONE;
         pcpw_pkg::ST_CHECK:
            state_in = outside ? pcpw_pkg::ST_REM : pcpw_pkg::ST_NEXT;
         pcpw_pkg::ST_REM:
            if (div_sts.done) state_in = pcpw_pkg::ST_MUL1;
         pcpw_pkg::ST_MUL1:  state_in = pcpw_pkg::ST_MUL2;
         pcpw_pkg::ST_MUL2:  state_in = pcpw_pkg::ST_SUM;
         pcpw_pkg::ST_SUM:   state_in = pcpw_pkg::ST_MUL3;
         pcpw_pkg::ST_MUL3:  state_in = pcpw_pkg::ST_STORE;
         pcpw_pkg::ST_STORE: state_in = pcpw_pkg::ST_NEXT;
         pcpw_pkg::ST_NEXT:
            if (axis_ff != pcpw_pkg::AX_Z)
               state_in = pcpw_pkg::ST_CHECK;
            else if ((rnd_ff + 1'b1) > RND_W'(ROUND_LIMIT) || !crossed_ff)
               state_in = pcpw_pkg::ST_DONE;
            else
               state_in = pcpw_pkg::ST_CHECK;
         pcpw_pkg::ST_DONE:  state_in = pcpw_pkg::ST_IDLE;
         default:            state_in = pcpw_pkg::ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      axis_in      = axis_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      rnd_in       = rnd_ff;
      crossed_in   = crossed_ff;
      limit_in     = limit_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      rsp_valid_in = 1'b0;
      div_ctl.start    = 1'b0;
      div_ctl.dividend = cur[31] ? ({cur[31], cur} + {2'b00, box_ff})
                                 : {cur[31], cur};
      case (state_ff)
         pcpw_pkg::ST_IDLE:
            if (start) begin
               x_in       = req_data.in_x;
               y_in       = req_data.in_y;
               z_in       = req_data.in_z;
               axis_in    = pcpw_pkg::AX_X;
               rnd_in     = '0;
               crossed_in = 1'b0;
               limit_in   = 1'b0;
            end
         pcpw_pkg::ST_CHECK:
            if (outside) begin
               div_ctl.start = 1'b1;
               crossed_in    = 1'b1;
            end
         pcpw_pkg::ST_REM:
            if (div_sts.done) begin
               case (axis_ff)
                  pcpw_pkg::AX_X: x_in = div_sts.rem[31:0];
                  pcpw_pkg::AX_Y: y_in = div_sts.rem[31:0];
                  default:        z_in = div_sts.rem[31:0];
               endcase
            end
         pcpw_pkg::ST_MUL1: acc_in = 52'(prodq);
         pcpw_pkg::ST_MUL2: acc_in = acc_ff + 52'(prodq);
         pcpw_pkg::ST_SUM: begin
            acc_in = acc_ff + 52'(coef_d_ff);
         end
         pcpw_pkg::ST_MUL3: res_in = pcpw_pkg::sat32(52'(prodq));
         pcpw_pkg::ST_STORE:
            case (axis_ff)
               pcpw_pkg::AX_X: z_in = res_ff;
               pcpw_pkg::AX_Y: x_in = res_ff;
               default:        y_in = res_ff;
            endcase
         pcpw_pkg::ST_NEXT:
            if (axis_ff != pcpw_pkg::AX_Z) begin
               axis_in = pcpw_pkg::axis_type'(axis_ff + 2'd1);
            end else begin
               axis_in    = pcpw_pkg::AX_X;
               rnd_in     = rnd_ff + 1'b1;
               crossed_in = 1'b0;
               if ((rnd_ff + 1'b1) > RND_W'(ROUND_LIMIT))
                  limit_in = 1'b1;
            end
         pcpw_pkg::ST_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
      if (state_ff == pcpw_pkg::ST_SUM)
         res_in = neg_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcpw_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         axis_ff      <= pcpw_pkg::AX_X;
         rnd_ff       <= '0;
         crossed_ff   <= 1'b0;
         limit_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         axis_ff      <= axis_in;
         rnd_ff       <= rnd_in;
         crossed_ff   <= crossed_in;
         limit_ff     <= limit_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      acc_ff <= acc_in;
      res_ff <= res_in;
   end

   // ST_SUM stores -(sum) saturated into res for the reciprocal multiply
   always_comb begin
      busy                 = (state_ff != pcpw_pkg::ST_IDLE);
      rsp_valid            = rsp_valid_ff;
      rsp_data.out_x       = x_ff;
      rsp_data.out_y       = y_ff;
      rsp_data.out_z       = z_ff;
      rsp_data.rounds_used = (rnd_ff > RND_W'(63)) ? 6'd63 : 6'(rnd_ff);
      rsp_data.limit_hit   = limit_ff;
   end

`ifndef SYNTHESIS
   a_rnd_bound: assert property (@(posedge clock) disable iff (reset)
      rnd_ff <= RND_W'(ROUND_LIMIT + 1))
      else $error("round count past limit");
   a_limit_at_end: assert property (@(posedge clock) disable iff (reset)
      limit_ff |-> rnd_ff == RND_W'(ROUND_LIMIT + 1))
      else $error("limit flag without round count");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff) == pcpw_pkg::ST_DONE)
      else $error("response outside done");
   a_rem_in_rem_state: assert property (@(posedge clock) disable iff (reset)
      div_sts.busy |-> state_ff == pcpw_pkg::ST_REM)
      else $error("divider busy outside remainder step");
`endif

endmodule
